>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion macros used by the midpoint unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the following cycle.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg
// Types and constants of the sliding window midpoint unit.
// ----------------------------------------------------------------------------
package swm_pkg;

    // Width of the window length register.
    localparam int CFG_BITS = 7;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_SUM  = 3'b100
    } state_t;

    // Control of one window rescan.
    typedef struct packed {
        logic do_max;
        logic do_min;
        logic first;
    } scan_ctl_t;

endpackage

>>> rtl/sliding_window_midpoint_unit.sv
// ----------------------------------------------------------------------------
// sliding_window_midpoint_unit
// Running max plus min over a sliding window of signed fixed point samples.
// ----------------------------------------------------------------------------
// Usage:
// Samples arrive on the s_ channel as words with a series start flag. Each
// word is written into a ring store. Once window_length samples have been
// seen since the series start, the word yields max plus min of the window on
// the m_ channel; earlier words yield nothing.
// A word that yields nothing leaves the sequencer idle. A word whose extremes
// stay in the window goes through the sum step to its result. When an extreme
// leaves the window, or after a series start or a length write, the window is
// rescanned through the store's single read port, one sample per cycle. s_ready
// is high only while the sequencer is idle; the result sits in an output
// register, so the next word is taken while it waits. A stalled receiver holds
// the result, and a further result waits in the sum step. The cfg_ channel
// writes window_length and is always ready; the user must write it only while
// the block is idle; the block does not enforce this. Reset sets the length to 1,
// starts a new series and drops any pending result; the store needs no clearing.
// ----------------------------------------------------------------------------
module sliding_window_midpoint_unit
    import swm_pkg::*;
#(
    parameter int WINDOW_DEPTH = 64,
    parameter int SAMPLE_BITS  = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_BITS-1:0]           cfg_window_length,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_start_series,
    input  logic signed [SAMPLE_BITS-1:0] s_sample,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS:0]   m_midpoint_half_units
);

`include "assert_macros.svh"

    localparam int PW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam int XW = (CW > CFG_BITS) ? CW : CFG_BITS;
    localparam logic [PW:0]   DEPTH_P  = (PW + 1)'(WINDOW_DEPTH);
    localparam logic [XW-1:0] DEPTH_X  = XW'(WINDOW_DEPTH);
    localparam logic [CW-1:0] DEPTH_C  = CW'(WINDOW_DEPTH);
    localparam logic [PW-1:0] LAST_POS = PW'(WINDOW_DEPTH - 1);

    state_t                        state_reg, state_next;
    logic [CFG_BITS-1:0]           len_cfg_reg, len_cfg_next;
    logic [PW-1:0]                 wp_reg, wp_next;
    logic [CW-1:0]                 seen_reg, seen_next;
    logic                          max_valid_reg, max_valid_next;
    logic [PW-1:0]                 max_pos_reg, max_pos_next;
    logic [PW-1:0]                 min_pos_reg, min_pos_next;
    logic signed [SAMPLE_BITS-1:0] max_val_reg, max_val_next;
    logic signed [SAMPLE_BITS-1:0] min_val_reg, min_val_next;
    logic [PW-1:0]                 scan_addr_reg, scan_addr_next;
    logic [CW-1:0]                 scan_left_reg, scan_left_next;
    scan_ctl_t                     scan_reg, scan_next;
    logic                          rd_valid_reg, rd_valid_next;
    logic [PW-1:0]                 rd_pos_reg, rd_pos_next;
    logic                          m_valid_reg, m_valid_next;
    logic signed [SAMPLE_BITS:0]   m_mid_reg, m_mid_next;

    logic [XW-1:0]                 len_x;
    logic [XW-1:0]                 len_eff;
    logic [PW:0]                   len_p;
    logic [PW:0]                   lm1_p;
    logic [PW-1:0]                 w_pos;
    logic [PW:0]                   w_p;
    logic [PW:0]                   exp_p;
    logic [PW:0]                   first_p;
    logic [PW-1:0]                 expire_pos;
    logic [PW-1:0]                 first_pos;
    logic [PW-1:0]                 wp_inc;
    logic [PW-1:0]                 scan_inc;
    logic [CW-1:0]                 seen_base;
    logic [CW-1:0]                 seen_new;
    logic                          result_due;
    logic                          valid_eff;
    logic                          hit_max;
    logic                          hit_min;
    logic                          ram_we;
    logic                          ram_re;
    logic [SAMPLE_BITS-1:0]        ram_rdata;
    logic signed [SAMPLE_BITS-1:0] rd_val;
    logic signed [SAMPLE_BITS:0]   sum;

    swm_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW_DEPTH)
    ) u_store (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (w_pos),
        .wdata (s_sample),
        .re    (ram_re),
        .raddr (scan_addr_reg),
        .rdata (ram_rdata)
    );

    // Effective length: zero counts as one, and the store depth caps it.
    assign len_x   = XW'(len_cfg_reg);
    assign len_eff = (len_x == '0) ? XW'(1) : ((len_x > DEPTH_X) ? DEPTH_X : len_x);
    assign len_p   = (PW + 1)'(len_eff);
    assign lm1_p   = len_p - (PW + 1)'(1);

    assign w_pos     = s_start_series ? '0 : wp_reg;
    assign w_p       = {1'b0, w_pos};
    assign wp_inc    = (w_pos == LAST_POS) ? '0 : w_pos + PW'(1);
    assign scan_inc  = (scan_addr_reg == LAST_POS) ? '0 : scan_addr_reg + PW'(1);
    assign valid_eff = s_start_series ? 1'b0 : max_valid_reg;
    assign seen_base = s_start_series ? '0 : seen_reg;
    assign seen_new  = (seen_base < DEPTH_C) ? seen_base + CW'(1) : seen_base;
    assign result_due = XW'(seen_new) >= len_eff;

    // Slot that drops out of the window with this word, and the oldest slot
    // still inside it.
    assign exp_p      = (w_p >= len_p) ? w_p - len_p : w_p + DEPTH_P - len_p;
    assign first_p    = (w_p >= lm1_p) ? w_p - lm1_p : w_p + DEPTH_P - lm1_p;
    assign expire_pos = exp_p[PW-1:0];
    assign first_pos  = first_p[PW-1:0];

    assign hit_max = max_pos_reg == expire_pos;
    assign hit_min = min_pos_reg == expire_pos;
    assign rd_val  = $signed(ram_rdata);
    assign sum     = {max_val_reg[SAMPLE_BITS-1], max_val_reg}
                   + {min_val_reg[SAMPLE_BITS-1], min_val_reg};

    always_comb begin
        state_next     = state_reg;
        len_cfg_next   = len_cfg_reg;
        wp_next        = wp_reg;
        seen_next      = seen_reg;
        max_valid_next = max_valid_reg;
        max_pos_next   = max_pos_reg;
        min_pos_next   = min_pos_reg;
        max_val_next   = max_val_reg;
        min_val_next   = min_val_reg;
        scan_addr_next = scan_addr_reg;
        scan_left_next = scan_left_reg;
        scan_next      = scan_reg;
        rd_valid_next  = 1'b0;
        rd_pos_next    = rd_pos_reg;
        m_valid_next   = m_valid_reg;
        m_mid_next     = m_mid_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    ram_we         = 1'b1;
                    wp_next        = wp_inc;
                    seen_next      = seen_new;
                    max_valid_next = valid_eff;
                    scan_addr_next = first_pos;
                    scan_left_next = CW'(len_eff);
                    if (result_due) begin
                        if (!valid_eff) begin
                            scan_next      = '{do_max: 1'b1, do_min: 1'b1, first: 1'b1};
                            max_valid_next = 1'b1;
                            state_next     = ST_SCAN;
                        end else begin
                            if (!hit_max && s_sample >= max_val_reg) begin
                                max_val_next = s_sample;
                                max_pos_next = w_pos;
                            end
                            if (!hit_min && s_sample <= min_val_reg) begin
                                min_val_next = s_sample;
                                min_pos_next = w_pos;
                            end
                            scan_next = '{do_max: hit_max, do_min: hit_min, first: 1'b1};
                            state_next = (hit_max || hit_min) ? ST_SCAN : ST_SUM;
                        end
                    end
                end
            end
            ST_SCAN: begin
                // Reads go out oldest first; their data comes back in the following cycle.
                if (scan_left_reg != '0) begin
                    ram_re         = 1'b1;
                    rd_valid_next  = 1'b1;
                    rd_pos_next    = scan_addr_reg;
                    scan_addr_next = scan_inc;
                    scan_left_next = scan_left_reg - CW'(1);
                end else begin
                    state_next = ST_SUM;
                end
                if (rd_valid_reg) begin
                    if (scan_reg.do_max && (scan_reg.first || rd_val >= max_val_reg)) begin
                        max_val_next = rd_val;
                        max_pos_next = rd_pos_reg;
                    end
                    if (scan_reg.do_min && (scan_reg.first || rd_val <= min_val_reg)) begin
                        min_val_next = rd_val;
                        min_pos_next = rd_pos_reg;
                    end
                    scan_next.first = 1'b0;
                end
            end
            ST_SUM: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_mid_next   = sum;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // A new length forces a full rescan at the next result.
        if (cfg_valid) begin
            len_cfg_next   = cfg_window_length;
            max_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            len_cfg_reg   <= CFG_BITS'(1);
            wp_reg        <= '0;
            seen_reg      <= '0;
            max_valid_reg <= 1'b0;
            max_pos_reg   <= '0;
            min_pos_reg   <= '0;
            scan_left_reg <= '0;
            scan_reg      <= '0;
            rd_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            len_cfg_reg   <= len_cfg_next;
            wp_reg        <= wp_next;
            seen_reg      <= seen_next;
            max_valid_reg <= max_valid_next;
            max_pos_reg   <= max_pos_next;
            min_pos_reg   <= min_pos_next;
            scan_left_reg <= scan_left_next;
            scan_reg      <= scan_next;
            rd_valid_reg  <= rd_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        max_val_reg   <= max_val_next;
        min_val_reg   <= min_val_next;
        scan_addr_reg <= scan_addr_next;
        rd_pos_reg    <= rd_pos_next;
        m_mid_reg     <= m_mid_next;
    end

    assign cfg_ready             = 1'b1;
    assign s_ready               = state_reg == ST_IDLE;
    assign m_valid               = m_valid_reg;
    assign m_midpoint_half_units = m_mid_reg;

    `ASSERT_SAME(a_rd_in_scan, aclk, aresetn, rd_valid_reg, state_reg == ST_SCAN,
        "store read data returned outside a rescan")
    `ASSERT_NEXT(a_scan_ends, aclk, aresetn, (state_reg == ST_SCAN) && (scan_left_reg == '0),
        state_reg == ST_SUM, "rescan did not hand over to the sum step")
    `ASSERT_SAME(a_sum_valid, aclk, aresetn, state_reg == ST_SUM, max_valid_reg,
        "sum step reached without valid extremes")
    `ASSERT_NEXT(a_sum_out, aclk, aresetn, (state_reg == ST_SUM) && (!m_valid_reg || m_ready),
        m_valid_reg && (state_reg == ST_IDLE), "free output register not loaded by the sum step")

endmodule

>>> rtl/swm_ram.sv
// ----------------------------------------------------------------------------
// swm_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module swm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
